### src/huffman_stream_decoder_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef HUFFMAN_STREAM_DECODER_MACROS_SVH
`define HUFFMAN_STREAM_DECODER_MACROS_SVH

// Condition must hold at every edge out of reset.
`define HSD_ASSERT_HOLDS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define HSD_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define HSD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/hsd_pkg.sv
package hsd_pkg;

    localparam int NODE_COUNT_DEF  = 512;
    localparam int STACK_DEPTH_DEF = 256;

    localparam int SYMBOL_W     = 8;
    localparam int SYMBOL_BITS  = 8;
    localparam int MARKER_BYTES = 3;

    // position of the last bit of a byte in the bit counter
    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_MARKER = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_HDR   = 8'b0000_0010,
        S_POP   = 8'b0000_0100,
        S_PATCH = 8'b0000_1000,
        S_DAT   = 8'b0001_0000,
        S_CHK   = 8'b0010_0000,
        S_FLUSH = 8'b0100_0000,
        S_END   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic load;
        logic advance;
        logic restart;
        logic hdr_step;
        logic patch_rd;
        logic patch_wr;
        logic dat_step;
        logic dat_chk;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic sym_pending;
        logic sym_last;
        logic stack_empty;
        logic root_leaf;
        logic rd_leaf;
        logic held_valid;
        logic out_room;
    } status_t;

endpackage

### src/hsd_datapath.sv
`include "huffman_stream_decoder_macros.svh"

module hsd_datapath #(
    parameter int NODE_COUNT  = hsd_pkg::NODE_COUNT_DEF,
    parameter int STACK_DEPTH = hsd_pkg::STACK_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  hsd_pkg::cmd_t                  cmd,
    output hsd_pkg::status_t               st,
    input  logic [7:0]                     s_data_byte,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic [hsd_pkg::SYMBOL_W-1:0]   m_symbol,
    output logic                           m_run_end
);

    localparam int SW    = hsd_pkg::SYMBOL_W;
    localparam int IDXW  = $clog2(NODE_COUNT);
    localparam int NUW   = $clog2(NODE_COUNT + 1);
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int DW    = $clog2(STACK_DEPTH + 1);
    localparam int ENTW  = IDXW + SW + 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NODE_COUNT - 1);

    // node entry: leaf flag, right child index, symbol
    logic [ENTW-1:0] node_mem [NODE_COUNT];
    logic [IDXW-1:0] stack_mem [STACK_DEPTH];

    logic [7:0]      byte_reg,        byte_next;
    logic [DW-1:0]   stack_depth_reg, stack_depth_next;
    logic [NUW-1:0]  nodes_used_reg,  nodes_used_next;
    logic [3:0]      sym_left_reg,    sym_left_next;
    logic [SW-1:0]   shift_reg,       shift_next;
    logic [IDXW-1:0] walk_reg,        walk_next;
    logic [ENTW-1:0] cur_entry_reg,   cur_entry_next;
    logic [ENTW-1:0] root_reg,        root_next;
    logic [IDXW-1:0] p_reg,           p_next;
    logic            held_valid_reg,  held_valid_next;
    logic [SW-1:0]   held_sym_reg,    held_sym_next;
    logic            out_valid_reg,   out_valid_next;
    logic [SW-1:0]   out_sym_reg,     out_sym_next;
    logic            out_end_reg,     out_end_next;
    logic [ENTW-1:0] node_rdata_reg;
    logic [IDXW-1:0] stack_rdata_reg;

    logic            bit_val;
    logic            nodes_full;
    logic [IDXW-1:0] nu_clamped;
    logic [NUW-1:0]  nu_dec;
    logic [IDXW-1:0] leaf_idx;
    logic [SW-1:0]   shift_new;
    logic [ENTW-1:0] cur_entry;
    logic [IDXW-1:0] cur_right;
    logic [IDXW-1:0] right_cl;
    logic [IDXW:0]   walk_inc;
    logic [IDXW-1:0] inc_cl;
    logic [IDXW-1:0] walk_target;
    logic [DW-1:0]   depth_dec;

    logic            node_we;
    logic [IDXW-1:0] node_waddr;
    logic [ENTW-1:0] node_wdata;
    logic            node_re;
    logic [IDXW-1:0] node_raddr;
    logic            stack_we;
    logic            stack_re;
    logic [SAW-1:0]  stack_waddr;
    logic [SAW-1:0]  stack_raddr;

    logic            root_leaf;
    logic            rd_leaf;
    logic            out_room;
    logic            emit_en;
    logic [SW-1:0]   emit_sym;
    logic            push;

    assign bit_val    = byte_reg[7];
    assign nodes_full = (nodes_used_reg >= NUW'(NODE_COUNT));
    assign nu_clamped = nodes_full ? LAST_IDX : nodes_used_reg[IDXW-1:0];
    assign nu_dec     = nodes_used_reg - NUW'(1);
    assign leaf_idx   = (nodes_used_reg == '0) ? '0 : nu_dec[IDXW-1:0];
    assign shift_new  = {shift_reg[SW-2:0], bit_val};
    assign depth_dec  = stack_depth_reg - DW'(1);

    // the root entry is shadowed so the walk never has to read it
    assign cur_entry   = (walk_reg == '0) ? root_reg : cur_entry_reg;
    assign cur_right   = cur_entry[IDXW+SW-1:SW];
    assign right_cl    = (cur_right > LAST_IDX) ? LAST_IDX : cur_right;
    assign walk_inc    = {1'b0, walk_reg} + (IDXW+1)'(1);
    assign inc_cl      = (walk_inc > (IDXW+1)'(NODE_COUNT - 1)) ? LAST_IDX
                                                                : walk_inc[IDXW-1:0];
    assign walk_target = bit_val ? right_cl : inc_cl;

    assign root_leaf = root_reg[ENTW-1];
    assign rd_leaf   = node_rdata_reg[ENTW-1];
    assign out_room  = !out_valid_reg || m_ready;

    assign emit_en  = (cmd.dat_step && root_leaf) || (cmd.dat_chk && rd_leaf);
    assign emit_sym = cmd.dat_chk ? node_rdata_reg[SW-1:0] : root_reg[SW-1:0];
    assign push     = held_valid_reg && (emit_en || cmd.flush);

    // memory port control
    always_comb begin
        node_we     = 1'b0;
        node_waddr  = nu_clamped;
        node_wdata  = '0;
        node_re     = 1'b0;
        node_raddr  = walk_target;
        stack_we    = 1'b0;
        stack_re    = 1'b0;
        stack_waddr = stack_depth_reg[SAW-1:0];
        stack_raddr = depth_dec[SAW-1:0];
        if (cmd.hdr_step) begin
            node_we = 1'b1;
            if (sym_left_reg != '0) begin
                if (sym_left_reg == 4'd1) begin
                    node_waddr = leaf_idx;
                    node_wdata = {1'b1, {IDXW{1'b0}}, shift_new};
                    stack_re   = (stack_depth_reg != '0);
                end else begin
                    node_we = 1'b0;
                end
            end else begin
                node_waddr = nu_clamped;
                node_wdata = {bit_val, {(IDXW+SW){1'b0}}};
                stack_we   = !bit_val && (stack_depth_reg < DW'(STACK_DEPTH));
            end
        end
        if (cmd.patch_wr) begin
            node_we    = 1'b1;
            node_waddr = p_reg;
            node_wdata = {node_rdata_reg[ENTW-1], nu_clamped, node_rdata_reg[SW-1:0]};
        end
        if (cmd.patch_rd) begin
            node_re    = 1'b1;
            node_raddr = stack_rdata_reg;
        end
        if (cmd.dat_step && !root_leaf) begin
            node_re = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            node_rdata_reg <= node_mem[node_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= nu_clamped;
        end
        if (stack_re) begin
            stack_rdata_reg <= stack_mem[stack_raddr];
        end
    end

    always_comb begin
        byte_next        = byte_reg;
        stack_depth_next = stack_depth_reg;
        nodes_used_next  = nodes_used_reg;
        sym_left_next    = sym_left_reg;
        shift_next       = shift_reg;
        walk_next        = walk_reg;
        cur_entry_next   = cur_entry_reg;
        root_next        = root_reg;
        p_next           = p_reg;
        held_valid_next  = held_valid_reg;
        held_sym_next    = held_sym_reg;
        out_sym_next     = out_sym_reg;
        out_end_next     = out_end_reg;
        out_valid_next   = (out_valid_reg && m_ready) ? 1'b0 : out_valid_reg;

        if (cmd.load) begin
            byte_next = s_data_byte;
        end else if (cmd.advance) begin
            byte_next = {byte_reg[6:0], 1'b0};
        end

        if (cmd.hdr_step) begin
            if (sym_left_reg != '0) begin
                shift_next    = shift_new;
                sym_left_next = sym_left_reg - 4'd1;
                if (sym_left_reg == 4'd1 && stack_depth_reg != '0) begin
                    stack_depth_next = depth_dec;
                end
            end else begin
                if (!nodes_full) begin
                    nodes_used_next = nodes_used_reg + NUW'(1);
                end
                if (bit_val) begin
                    sym_left_next = 4'(hsd_pkg::SYMBOL_BITS);
                    shift_next    = '0;
                end else if (stack_depth_reg < DW'(STACK_DEPTH)) begin
                    stack_depth_next = stack_depth_reg + DW'(1);
                end
            end
        end

        if (cmd.patch_rd) begin
            p_next = stack_rdata_reg;
        end

        if (cmd.dat_step) begin
            walk_next = root_leaf ? '0 : walk_target;
        end
        if (cmd.dat_chk) begin
            if (rd_leaf) begin
                walk_next = '0;
            end else begin
                cur_entry_next = node_rdata_reg;
            end
        end

        // keep the root shadow coherent with the table
        if (node_we && node_waddr == '0) begin
            root_next = node_wdata;
        end

        // one symbol is held back so run_end can be set on the byte's last one
        if (push) begin
            out_valid_next = 1'b1;
            out_sym_next   = held_sym_reg;
            out_end_next   = cmd.flush;
        end
        if (emit_en) begin
            held_valid_next = 1'b1;
            held_sym_next   = emit_sym;
        end else if (cmd.flush) begin
            held_valid_next = 1'b0;
        end

        if (cmd.restart) begin
            stack_depth_next = '0;
            nodes_used_next  = '0;
            sym_left_next    = '0;
            shift_next       = '0;
            walk_next        = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_depth_reg <= '0;
            nodes_used_reg  <= '0;
            sym_left_reg    <= '0;
            shift_reg       <= '0;
            walk_reg        <= '0;
            root_reg        <= '0;
            held_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            stack_depth_reg <= stack_depth_next;
            nodes_used_reg  <= nodes_used_next;
            sym_left_reg    <= sym_left_next;
            shift_reg       <= shift_next;
            walk_reg        <= walk_next;
            root_reg        <= root_next;
            held_valid_reg  <= held_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg      <= byte_next;
        cur_entry_reg <= cur_entry_next;
        p_reg         <= p_next;
        held_sym_reg  <= held_sym_next;
        out_sym_reg   <= out_sym_next;
        out_end_reg   <= out_end_next;
    end

    assign st.sym_pending = (sym_left_reg != '0);
    assign st.sym_last    = (sym_left_reg == 4'd1);
    assign st.stack_empty = (stack_depth_reg == '0);
    assign st.root_leaf   = root_leaf;
    assign st.rd_leaf     = rd_leaf;
    assign st.held_valid  = held_valid_reg;
    assign st.out_room    = out_room;

    assign m_valid   = out_valid_reg;
    assign m_symbol  = out_sym_reg;
    assign m_run_end = out_end_reg;

    logic depth_ok;
    logic nodes_ok;
    assign depth_ok = (stack_depth_reg <= DW'(STACK_DEPTH));
    assign nodes_ok = (nodes_used_reg <= NUW'(NODE_COUNT));

    `HSD_ASSERT_IMPLIES(a_push_has_room, aclk, aresetn, push, out_room, "result pushed over a full output")
    `HSD_ASSERT_HOLDS(a_depth_bound, aclk, aresetn, depth_ok, "pending stack depth out of range")
    `HSD_ASSERT_HOLDS(a_nodes_bound, aclk, aresetn, nodes_ok, "node count out of range")

endmodule

### src/hsd_ctrl.sv
`include "huffman_stream_decoder_macros.svh"

module hsd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_last_byte,
    input  hsd_pkg::status_t st,
    output hsd_pkg::cmd_t    cmd
);

    hsd_pkg::state_t state_reg,  state_next;
    hsd_pkg::phase_t phase_reg,  phase_next;
    logic [1:0]      marker_reg, marker_next;
    logic [2:0]      bit_cnt_reg, bit_cnt_next;
    logic            last_reg,   last_next;
    logic            can_emit;

    assign can_emit = !st.held_valid || st.out_room;
    assign s_ready  = (state_reg == hsd_pkg::S_IDLE);

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        marker_next  = marker_reg;
        bit_cnt_next = bit_cnt_reg;
        last_next    = last_reg;
        cmd          = '0;

        case (state_reg)
            hsd_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd.load     = 1'b1;
                    last_next    = s_last_byte;
                    bit_cnt_next = '0;
                    case (phase_reg)
                        hsd_pkg::PH_MARKER: begin
                            // marker bytes are dropped in the accept cycle
                            if (marker_reg > 2'd1) begin
                                marker_next = marker_reg - 2'd1;
                            end else begin
                                marker_next = '0;
                                phase_next  = hsd_pkg::PH_DATA;
                            end
                            if (s_last_byte) begin
                                cmd.restart = 1'b1;
                                phase_next  = hsd_pkg::PH_HEADER;
                                marker_next = 2'(hsd_pkg::MARKER_BYTES);
                            end
                        end
                        hsd_pkg::PH_DATA: begin
                            state_next = hsd_pkg::S_DAT;
                        end
                        default: begin
                            phase_next = hsd_pkg::PH_HEADER;
                            state_next = hsd_pkg::S_HDR;
                        end
                    endcase
                end
            end
            hsd_pkg::S_HDR: begin
                cmd.hdr_step = 1'b1;
                if (st.sym_pending && st.sym_last) begin
                    if (st.stack_empty) begin
                        // header complete: drop the rest of this byte
                        phase_next  = hsd_pkg::PH_MARKER;
                        marker_next = 2'(hsd_pkg::MARKER_BYTES);
                        state_next  = hsd_pkg::S_END;
                    end else begin
                        state_next = hsd_pkg::S_POP;
                    end
                end else begin
                    cmd.advance  = 1'b1;
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg == hsd_pkg::LAST_BIT) begin
                        state_next = hsd_pkg::S_END;
                    end
                end
            end
            hsd_pkg::S_POP: begin
                cmd.patch_rd = 1'b1;
                state_next   = hsd_pkg::S_PATCH;
            end
            hsd_pkg::S_PATCH: begin
                cmd.patch_wr = 1'b1;
                cmd.advance  = 1'b1;
                bit_cnt_next = bit_cnt_reg + 3'd1;
                state_next   = (bit_cnt_reg == hsd_pkg::LAST_BIT) ? hsd_pkg::S_END
                                                                  : hsd_pkg::S_HDR;
            end
            hsd_pkg::S_DAT: begin
                if (!st.root_leaf || can_emit) begin
                    cmd.dat_step = 1'b1;
                    if (st.root_leaf) begin
                        cmd.advance  = 1'b1;
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        if (bit_cnt_reg == hsd_pkg::LAST_BIT) begin
                            state_next = hsd_pkg::S_FLUSH;
                        end
                    end else begin
                        state_next = hsd_pkg::S_CHK;
                    end
                end
            end
            hsd_pkg::S_CHK: begin
                if (!st.rd_leaf || can_emit) begin
                    cmd.dat_chk  = 1'b1;
                    cmd.advance  = 1'b1;
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                    state_next   = (bit_cnt_reg == hsd_pkg::LAST_BIT) ? hsd_pkg::S_FLUSH
                                                                      : hsd_pkg::S_DAT;
                end
            end
            hsd_pkg::S_FLUSH: begin
                if (!st.held_valid || st.out_room) begin
                    cmd.flush  = st.held_valid;
                    state_next = hsd_pkg::S_END;
                end
            end
            hsd_pkg::S_END: begin
                if (last_reg) begin
                    cmd.restart = 1'b1;
                    phase_next  = hsd_pkg::PH_HEADER;
                    marker_next = 2'(hsd_pkg::MARKER_BYTES);
                end
                state_next = hsd_pkg::S_IDLE;
            end
            default: begin
                state_next = hsd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hsd_pkg::S_IDLE;
            phase_reg   <= hsd_pkg::PH_HEADER;
            marker_reg  <= 2'(hsd_pkg::MARKER_BYTES);
            bit_cnt_reg <= '0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            marker_reg  <= marker_next;
            bit_cnt_reg <= bit_cnt_next;
            last_reg    <= last_next;
        end
    end

    logic step_cmds_ok;
    logic hdr_accept;
    logic in_hdr;
    logic phase_is_hdr;
    assign step_cmds_ok = $onehot0({cmd.hdr_step, cmd.patch_rd, cmd.patch_wr,
                                    cmd.dat_step, cmd.dat_chk, cmd.flush});
    assign hdr_accept   = s_valid && s_ready && (phase_reg != hsd_pkg::PH_MARKER)
                          && (phase_reg != hsd_pkg::PH_DATA);
    assign in_hdr       = (state_reg == hsd_pkg::S_HDR);
    assign phase_is_hdr = (phase_reg == hsd_pkg::PH_HEADER);

    `HSD_ASSERT_HOLDS(a_one_step_cmd, aclk, aresetn, step_cmds_ok, "datapath steps overlap")
    `HSD_ASSERT_NEXT(a_hdr_start, aclk, aresetn, hdr_accept, in_hdr, "header request did not start parsing")
    `HSD_ASSERT_IMPLIES(a_hdr_phase, aclk, aresetn, in_hdr, phase_is_hdr, "header step outside header phase")

endmodule

### src/huffman_stream_decoder.sv
// Streaming Huffman decoder. Each request carries one compressed byte, read MSB
// first. Bytes first build the code tree from a preorder header (1 = leaf with an
// 8-bit symbol, 0 = internal node); the rest of the byte that closes the header is
// dropped, and the next three bytes are skipped as markers. Every later bit steps
// the tree walk (0 = left, 1 = right) and a leaf yields a symbol on the result
// channel; m_run_end marks the last symbol a byte produced, and a byte may produce
// none. A tree that is a single leaf yields its symbol for every bit. A request
// with last_byte set returns the decoder to header parsing once that byte is done;
// the tree stays in place. A request is taken only while the decoder is
// idle; the node table has one read port with a registered output, so a data bit
// takes a table read step (S_DAT) and a check of the read entry (S_CHK), and with a
// single-leaf tree only the S_DAT step. A header bit is an S_HDR step; a leaf that
// closes a pending right branch adds a stack read, table read and table write
// (S_HDR, S_POP, S_PATCH). A marker byte is dropped in the cycle it is accepted.
// A byte can stall on the result channel while a produced symbol waits there.
module huffman_stream_decoder #(
    parameter int NODE_COUNT  = hsd_pkg::NODE_COUNT_DEF,
    parameter int STACK_DEPTH = hsd_pkg::STACK_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // compressed byte requests
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_data_byte,
    input  logic                         s_last_byte,
    // decoded symbols
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [hsd_pkg::SYMBOL_W-1:0] m_symbol,
    output logic                         m_run_end
);

    hsd_pkg::cmd_t    cmd;
    hsd_pkg::status_t st;

    // sequencing: accept, per-bit steps, symbol flush, end-of-stream restart
    hsd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_last_byte (s_last_byte),
        .st          (st),
        .cmd         (cmd)
    );

    // node table, pending-node stack, tree walk and output register
    hsd_datapath #(
        .NODE_COUNT  (NODE_COUNT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .st          (st),
        .s_data_byte (s_data_byte),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_symbol    (m_symbol),
        .m_run_end   (m_run_end)
    );

endmodule
